@@ design/glpe_pkg.sv @@
// Shared types and constants for the GIF LZW pixel encoder.
package glpe_pkg;

    localparam int unsigned CODE_W = 12;
    localparam int unsigned PIX_W = 8;
    localparam int unsigned CW_W = 4;

    localparam logic [CODE_W-1:0] CLEAR_CODE = 12'd256;
    localparam logic [CODE_W-1:0] END_CODE = 12'd257;
    localparam logic [CODE_W-1:0] FIRST_FREE = 12'd258;
    localparam logic [CW_W-1:0] START_WIDTH = 4'd9;
    localparam logic [CW_W-1:0] MAX_WIDTH = 4'd12;

    // One dictionary entry: prefix code, appended pixel, next sibling link.
    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [PIX_W-1:0] pix;
        logic [CODE_W-1:0] sib;
    } dict_entry_t;

    // Code push toward the bit packer.
    typedef struct packed {
        logic valid;
        logic flush;
        logic [CODE_W-1:0] code;
        logic [CW_W-1:0] width;
    } pack_req_t;

endpackage

@@ design/glpe_dict.sv @@
// Dictionary storage: entry memory and first-child link memory.
module glpe_dict #(
    parameter int unsigned DICT_ENTRIES = 4096,
    localparam int unsigned AW = $clog2(DICT_ENTRIES)
) (
    input  logic                  clk,
    input  logic [AW-1:0]         a_raddr,
    output glpe_pkg::dict_entry_t a_rdata,
    input  logic                  a_we,
    input  logic [AW-1:0]         a_waddr,
    input  glpe_pkg::dict_entry_t a_wdata,
    input  logic [AW-1:0]         b_raddr,
    output logic [glpe_pkg::CODE_W-1:0] b_rdata,
    input  logic                  b_we,
    input  logic [AW-1:0]         b_waddr,
    input  logic [glpe_pkg::CODE_W-1:0] b_wdata
);
    import glpe_pkg::*;

    dict_entry_t entry_mem [DICT_ENTRIES];
    logic [CODE_W-1:0] child_mem [DICT_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            entry_mem[a_waddr] <= a_wdata;
        end
        a_rdata <= entry_mem[a_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            child_mem[b_waddr] <= b_wdata;
        end
        b_rdata <= child_mem[b_raddr];
    end

endmodule

@@ design/glpe_packer.sv @@
// LSB-first bit packer with a registered byte output.
module glpe_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  glpe_pkg::pack_req_t req,
    output logic                ready,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                last_byte
);
    import glpe_pkg::*;

    logic [19:0] acc_reg, acc_next;
    logic [4:0] cnt_reg, cnt_next;
    logic fl_reg, fl_next;
    logic ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic ol_reg, ol_next;
    logic [CODE_W-1:0] masked;
    logic drain;

    assign ready = (cnt_reg < 5'd8) && !fl_reg;
    assign masked = req.code & CODE_W'((13'd1 << req.width) - 13'd1);
    assign drain = (!ov_reg || !out_stall) && ((cnt_reg >= 5'd8) || (fl_reg && cnt_reg != 5'd0));

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        fl_next = fl_reg;
        ov_next = ov_reg && out_stall;
        ob_next = ob_reg;
        ol_next = ol_reg;
        if (drain)
        begin
            ov_next = 1'b1;
            ob_next = acc_reg[7:0];
            ol_next = fl_reg && (cnt_reg <= 5'd8);
            acc_next = acc_reg >> 8;
            cnt_next = (cnt_reg >= 5'd8) ? cnt_reg - 5'd8 : 5'd0;
            if (cnt_next == 5'd0)
            begin
                fl_next = 1'b0;
            end
        end
        else if (req.valid && ready)
        begin
            // A flush push carries the final code; its bits end the stream.
            acc_next = acc_reg | (20'(masked) << cnt_reg[2:0]);
            cnt_next = cnt_reg + 5'(req.width);
            if (req.flush)
            begin
                fl_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
            fl_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
            fl_reg <= fl_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
    end

    assign out_valid = ov_reg;
    assign out_byte = ob_reg;
    assign last_byte = ol_reg;

endmodule

@@ design/gif_lzw_pixel_encoder.sv @@
// Top level of the GIF LZW pixel encoder: lookup/insert sequencer.
// Sequencing: the first pixel of an image pushes the clear code; any other pixel reads the
//   child head, compares the chain entries one by one, and on a miss pushes a code (and a
//   clear code when the dictionary fills); a last pixel adds 2 pushes. A push waits while
//   the packer holds 8 or more bits. Input: one pixel at a time, accepted only in idle;
//   the time per pixel grows with the sibling chain walk.
// Reset (rst_n, async, active low) clears the sequencer and packer; the dictionary
//   memories are not cleared: links are checked against nf_reg, the next free code, instead.
module gif_lzw_pixel_encoder #(
    parameter int unsigned DICT_ENTRIES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] pixel,
    input  logic       last_pixel,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_byte
);
    import glpe_pkg::*;

    localparam int unsigned AW = $clog2(DICT_ENTRIES);
    localparam logic [CODE_W-1:0] CLEAR_AT = CODE_W'(DICT_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR0,
        S_RD_B,
        S_CHK_B,
        S_CHK_A,
        S_MISS,
        S_CLR2,
        S_CUR,
        S_END
    } state_t;

    state_t state_reg, state_next;
    logic [PIX_W-1:0] pix_reg, pix_next;
    logic last_reg, last_next;
    logic [CODE_W-1:0] cur_reg, cur_next;
    logic [CODE_W-1:0] nf_reg, nf_next;
    logic [CW_W-1:0] cw_reg, cw_next;
    logic started_reg, started_next;
    logic [CODE_W-1:0] p_reg, p_next;
    logic [CODE_W-1:0] head_reg, head_next;

    dict_entry_t a_rdata, a_wdata;
    logic [AW-1:0] a_raddr, a_waddr, b_raddr, b_waddr;
    logic a_we, b_we;
    logic [CODE_W-1:0] b_rdata, b_wdata;
    pack_req_t req;
    logic ready;
    logic [CODE_W-1:0] nf_inc;
    logic [CW_W-1:0] cw_grown;

    // A link is live only if it names a code created since the last restart.
    function automatic logic live(input logic [CODE_W-1:0] c, input logic [CODE_W-1:0] nf);
        live = (c >= FIRST_FREE) && (c < nf);
    endfunction

    glpe_dict #(.DICT_ENTRIES(DICT_ENTRIES)) u_dict (
        .clk(clk),
        .a_raddr(a_raddr), .a_rdata(a_rdata), .a_we(a_we), .a_waddr(a_waddr),
        .a_wdata(a_wdata),
        .b_raddr(b_raddr), .b_rdata(b_rdata), .b_we(b_we), .b_waddr(b_waddr),
        .b_wdata(b_wdata)
    );

    glpe_packer u_pack (
        .clk(clk), .rst_n(rst_n), .req(req), .ready(ready),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .last_byte(last_byte)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign nf_inc = nf_reg + 12'd1;
    // Width grows when the new entry's code equals 1 << width.
    assign cw_grown = ((nf_reg == CODE_W'(13'd1 << cw_reg)) && (cw_reg < MAX_WIDTH))
                      ? cw_reg + 4'd1 : cw_reg;

    always_comb
    begin
        state_next = state_reg;
        pix_next = pix_reg;
        last_next = last_reg;
        cur_next = cur_reg;
        nf_next = nf_reg;
        cw_next = cw_reg;
        started_next = started_reg;
        p_next = p_reg;
        head_next = head_reg;
        a_raddr = p_reg[AW-1:0];
        b_raddr = cur_reg[AW-1:0];
        a_we = 1'b0;
        b_we = 1'b0;
        a_waddr = nf_reg[AW-1:0];
        b_waddr = cur_reg[AW-1:0];
        a_wdata = '{prefix: cur_reg, pix: pix_reg, sib: head_reg};
        b_wdata = nf_reg;
        req = '{valid: 1'b0, flush: 1'b0, code: cur_reg, width: cw_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pix_next = pixel;
                    last_next = last_pixel;
                    state_next = started_reg ? S_RD_B : S_CLR0;
                end
            end
            S_CLR0:
            begin
                req.valid = 1'b1;
                req.code = CLEAR_CODE;
                if (ready)
                begin
                    cur_next = CODE_W'(pix_reg);
                    started_next = 1'b1;
                    state_next = last_reg ? S_CUR : S_IDLE;
                end
            end
            S_RD_B:
            begin
                state_next = S_CHK_B;
            end
            S_CHK_B:
            begin
                // A stale head from before a restart must not become a sibling link.
                head_next = live(b_rdata, nf_reg) ? b_rdata : '0;
                p_next = b_rdata;
                a_raddr = b_rdata[AW-1:0];
                state_next = live(b_rdata, nf_reg) ? S_CHK_A : S_MISS;
            end
            S_CHK_A:
            begin
                if (a_rdata.prefix == cur_reg && a_rdata.pix == pix_reg)
                begin
                    cur_next = p_reg;
                    state_next = last_reg ? S_CUR : S_IDLE;
                end
                else if (a_rdata.prefix == cur_reg && live(a_rdata.sib, nf_reg))
                begin
                    p_next = a_rdata.sib;
                    a_raddr = a_rdata.sib[AW-1:0];
                end
                else
                begin
                    state_next = S_MISS;
                end
            end
            S_MISS:
            begin
                req.valid = 1'b1;
                if (ready)
                begin
                    a_we = 1'b1;
                    b_we = 1'b1;
                    cw_next = cw_grown;
                    nf_next = nf_inc;
                    cur_next = CODE_W'(pix_reg);
                    if (nf_inc >= CLEAR_AT)
                    begin
                        state_next = S_CLR2;
                    end
                    else
                    begin
                        state_next = last_reg ? S_CUR : S_IDLE;
                    end
                end
            end
            S_CLR2:
            begin
                req.valid = 1'b1;
                req.code = CLEAR_CODE;
                if (ready)
                begin
                    nf_next = FIRST_FREE;
                    cw_next = START_WIDTH;
                    state_next = last_reg ? S_CUR : S_IDLE;
                end
            end
            S_CUR:
            begin
                req.valid = 1'b1;
                if (ready)
                begin
                    state_next = S_END;
                end
            end
            S_END:
            begin
                // End code goes out with the flush so the final byte is always marked.
                req.valid = 1'b1;
                req.code = END_CODE;
                req.flush = 1'b1;
                if (ready)
                begin
                    nf_next = FIRST_FREE;
                    cw_next = START_WIDTH;
                    cur_next = '0;
                    started_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg <= '0;
            nf_reg <= FIRST_FREE;
            cw_reg <= START_WIDTH;
            started_reg <= 1'b0;
            last_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg <= cur_next;
            nf_reg <= nf_next;
            cw_reg <= cw_next;
            started_reg <= started_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_reg <= pix_next;
        p_reg <= p_next;
        head_reg <= head_next;
    end

endmodule

@@ design/glpe_checker.sv @@
// Port-level checks for the GIF LZW pixel encoder, bound to the top level.
module glpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       last_byte
);

    // A stalled byte holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_byte))
        else $error("output byte changed while stalled");

    // One pixel at a time: a transaction closes the input for the next cycle.
    a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input open right after a transaction");

    // An offered byte carries known data.
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({out_byte, last_byte}))
        else $error("unknown output byte");

endmodule

bind gif_lzw_pixel_encoder glpe_checker u_glpe_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_byte(out_byte),
    .last_byte(last_byte)
);
